// ----- design/min_heap_priority_queue_top_defines.svh -----
// Assertion macros used by the checker of the min-heap priority queue.
`ifndef MIN_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define MHPQ_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("min heap queue check failed");

// Next-cycle implication, sampled on clk, disabled while arst_n is low.
`define MHPQ_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("min heap queue check failed");

`endif

// ----- design/mhpq_pkg.sv -----
// Shared constants and types of the min-heap priority queue.
package mhpq_pkg;

	// Capacity and field widths.
	localparam int DEPTH       = 256;
	localparam int KEY_BITS    = 32;
	localparam int HANDLE_BITS = 9;
	localparam int ADDR_BITS   = $clog2(DEPTH);
	localparam int COUNT_BITS  = $clog2(DEPTH + 1);
	localparam int CHILD_BITS  = ADDR_BITS + 2;
	localparam int STATUS_BITS = 2;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_DATA_BITS  = ((KEY_BITS + HANDLE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((KEY_BITS + HANDLE_BITS + COUNT_BITS + 7) / 8) * 8;

	// Bit offsets of the result fields inside the output data word.
	localparam int OUT_HANDLE_LSB = KEY_BITS;
	localparam int OUT_COUNT_LSB  = KEY_BITS + HANDLE_BITS;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_EXTRACT = 1'b1
	} op_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]    key;
		logic [HANDLE_BITS-1:0] handle;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

endpackage

// ----- design/mhpq_ram.sv -----
// Generic RAM with one write port and two registered read ports.
module mhpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]                          rd_data_a,
	output logic [WIDTH-1:0]                          rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write first in program order; a read sees a write from an earlier cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

// ----- design/min_heap_priority_queue_top.sv -----
// Top level of the binary min-heap priority queue with a sequenced sift unit.
//
// Usage:
// Items arrive on the s_ channel: s_tuser is the operation (insert or extract
// minimum), s_tdata carries the key and handle of an insert. Each item gives
// exactly one result item on the m_ channel: m_tuser is the status (ok, empty,
// full) and m_tdata carries the extracted key and handle and the entry count.
// One item is worked on at a time and s_tready is low until it is finished.
// The heap lives in a RAM with one write and two read ports; each tree level
// takes a read step (the parent or both children) and then a compare-and-write-back
// step (the moving entry stays in a register, so no swaps).
// A full insert and an extract from an empty heap go straight to the result;
// an extract with one entry held ends after reading the root.
// The next item is accepted the cycle after the result is registered.
// A finished result waits in the output register while the receiver stalls;
// the sequencer holds in its final step until that register is free.
// Reset empties the heap (count zero) at once; no clearing pass is needed.
module min_heap_priority_queue_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [mhpq_pkg::IN_DATA_BITS-1:0]    s_tdata,  // key, handle, zero pad
	input  logic                                 s_tuser,  // operation
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [mhpq_pkg::OUT_DATA_BITS-1:0]   m_tdata,  // out_key, out_handle, count, zero pad
	output logic [mhpq_pkg::STATUS_BITS-1:0]     m_tuser   // status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_EV,
		S_EX_RD,
		S_EX_EV,
		S_DN_RD,
		S_DN_EV,
		S_DONE
	} state_t;

	state_t                              state_q;
	mhpq_pkg::entry_t                    x_q;
	mhpq_pkg::entry_t                    res_q;
	logic [mhpq_pkg::ADDR_BITS-1:0]      pos_q;
	logic [mhpq_pkg::COUNT_BITS-1:0]     count_q;
	mhpq_pkg::status_t                   status_q;

	logic                                m_valid_q;
	mhpq_pkg::entry_t                    m_res_q;
	logic [mhpq_pkg::COUNT_BITS-1:0]     m_count_q;
	mhpq_pkg::status_t                   m_status_q;

	logic                                accept;
	mhpq_pkg::entry_t                    in_entry;
	logic [mhpq_pkg::ADDR_BITS-1:0]      parent;
	logic [mhpq_pkg::CHILD_BITS-1:0]     left_w;
	logic [mhpq_pkg::CHILD_BITS-1:0]     right_w;
	logic                                left_ok;
	logic                                right_ok;
	logic [mhpq_pkg::COUNT_BITS-1:0]     count_dec;

	logic                                ram_we;
	logic [mhpq_pkg::ADDR_BITS-1:0]      ram_wr_addr;
	mhpq_pkg::entry_t                    ram_wr_data;
	logic [mhpq_pkg::ADDR_BITS-1:0]      ram_rd_addr_a;
	logic [mhpq_pkg::ADDR_BITS-1:0]      ram_rd_addr_b;
	mhpq_pkg::entry_t                    rd_a;
	mhpq_pkg::entry_t                    rd_b;

	logic [mhpq_pkg::KEY_BITS-1:0]       cmp_lhs;
	logic [mhpq_pkg::KEY_BITS-1:0]       cmp_rhs;
	logic                                cmp_lt;
	logic                                take_left;
	mhpq_pkg::entry_t                    best_ent;
	logic                                take_right;
	logic                                out_free;

	// Handshake and input unpacking.
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_entry.key    = s_tdata[mhpq_pkg::KEY_BITS-1:0];
	assign in_entry.handle = s_tdata[mhpq_pkg::KEY_BITS+mhpq_pkg::HANDLE_BITS-1:
		mhpq_pkg::KEY_BITS];
	assign out_free = !m_valid_q || m_tready;

	// Tree index arithmetic around the current hole position.
	assign parent    = (pos_q - mhpq_pkg::ADDR_BITS'(1)) >> 1;
	assign left_w    = {1'b0, pos_q, 1'b1};
	assign right_w   = left_w + mhpq_pkg::CHILD_BITS'(1);
	assign left_ok   = left_w < mhpq_pkg::CHILD_BITS'(count_q);
	assign right_ok  = right_w < mhpq_pkg::CHILD_BITS'(count_q);
	assign count_dec = count_q - mhpq_pkg::COUNT_BITS'(1);

	// Shared key comparator: moving entry against the parent on the way up,
	// left child against the moving entry on the way down.
	always_comb begin
		if (state_q == S_UP_EV) begin
			cmp_lhs = x_q.key;
			cmp_rhs = rd_a.key;
		end else begin
			cmp_lhs = rd_a.key;
			cmp_rhs = x_q.key;
		end
	end
	assign cmp_lt = cmp_lhs < cmp_rhs;

	// The right child wins only when strictly smaller than the current best.
	assign take_left  = left_ok && cmp_lt;
	assign best_ent   = take_left ? rd_a : x_q;
	assign take_right = right_ok && (rd_b.key < best_ent.key);

	// RAM read addresses per sequencer step.
	always_comb begin
		unique case (state_q)
			S_EX_RD: begin
				ram_rd_addr_a = '0;
				ram_rd_addr_b = count_dec[mhpq_pkg::ADDR_BITS-1:0];
			end
			S_UP_RD: begin
				ram_rd_addr_a = parent;
				ram_rd_addr_b = parent;
			end
			default: begin
				ram_rd_addr_a = left_w[mhpq_pkg::ADDR_BITS-1:0];
				ram_rd_addr_b = right_w[mhpq_pkg::ADDR_BITS-1:0];
			end
		endcase
	end

	// RAM write: either the entry moving into the hole or the final placement.
	always_comb begin
		ram_we      = 1'b0;
		ram_wr_addr = pos_q;
		ram_wr_data = x_q;
		unique case (state_q)
			S_UP_RD: begin
				ram_we = (pos_q == '0);
			end
			S_UP_EV: begin
				ram_we = 1'b1;
				if (cmp_lt) begin
					ram_wr_data = rd_a;
				end
			end
			S_DN_EV: begin
				ram_we = 1'b1;
				if (take_right) begin
					ram_wr_data = rd_b;
				end else if (take_left) begin
					ram_wr_data = rd_a;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	mhpq_ram #(
		.WIDTH (mhpq_pkg::ENTRY_BITS),
		.DEPTH (mhpq_pkg::DEPTH)
	) u_ram (
		.clk       (clk),
		.we        (ram_we),
		.wr_addr   (ram_wr_addr),
		.wr_data   (ram_wr_data),
		.rd_addr_a (ram_rd_addr_a),
		.rd_addr_b (ram_rd_addr_b),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	// Sequencer, heap count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			x_q        <= '0;
			res_q      <= '0;
			pos_q      <= '0;
			count_q    <= '0;
			status_q   <= mhpq_pkg::ST_OK;
			m_valid_q  <= 1'b0;
			m_res_q    <= '0;
			m_count_q  <= '0;
			m_status_q <= mhpq_pkg::ST_OK;
		end else begin
			// The output register fills from the final step and empties when taken.
			if (state_q == S_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q <= '0;
						if (s_tuser == mhpq_pkg::OP_INSERT) begin
							if (count_q == mhpq_pkg::COUNT_BITS'(mhpq_pkg::DEPTH)) begin
								status_q <= mhpq_pkg::ST_FULL;
								state_q  <= S_DONE;
							end else begin
								status_q <= mhpq_pkg::ST_OK;
								x_q      <= in_entry;
								pos_q    <= count_q[mhpq_pkg::ADDR_BITS-1:0];
								count_q  <= count_q + mhpq_pkg::COUNT_BITS'(1);
								state_q  <= S_UP_RD;
							end
						end else begin
							if (count_q == '0) begin
								status_q <= mhpq_pkg::ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								status_q <= mhpq_pkg::ST_OK;
								state_q  <= S_EX_RD;
							end
						end
					end
				end
				S_UP_RD: begin
					// At the root the entry was written this cycle.
					state_q <= (pos_q == '0) ? S_DONE : S_UP_EV;
				end
				S_UP_EV: begin
					if (cmp_lt) begin
						pos_q   <= parent;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_EX_RD: begin
					state_q <= S_EX_EV;
				end
				S_EX_EV: begin
					// Root leaves as the result; the last entry sinks from the root.
					res_q   <= rd_a;
					x_q     <= rd_b;
					pos_q   <= '0;
					count_q <= count_dec;
					state_q <= (count_dec == '0) ? S_DONE : S_DN_RD;
				end
				S_DN_RD: begin
					state_q <= S_DN_EV;
				end
				S_DN_EV: begin
					if (take_right) begin
						pos_q   <= right_w[mhpq_pkg::ADDR_BITS-1:0];
						state_q <= S_DN_RD;
					end else if (take_left) begin
						pos_q   <= left_w[mhpq_pkg::ADDR_BITS-1:0];
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_res_q    <= res_q;
						m_count_q  <= count_q;
						m_status_q <= status_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output packing.
	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = mhpq_pkg::OUT_DATA_BITS'({m_count_q, m_res_q.handle, m_res_q.key});

endmodule

// ----- design/mhpq_checker.sv -----
// Port-level checker of the min-heap priority queue, bound to the top level.
`include "min_heap_priority_queue_top_defines.svh"

module mhpq_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic [mhpq_pkg::IN_DATA_BITS-1:0]    s_tdata,
	input logic                                 s_tuser,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [mhpq_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	input logic [mhpq_pkg::STATUS_BITS-1:0]     m_tuser
);

	logic [mhpq_pkg::OUT_COUNT_LSB-1:0]  res_entry;
	logic [mhpq_pkg::COUNT_BITS-1:0]     res_count;
	logic                                unused_in;

	assign res_entry = m_tdata[mhpq_pkg::OUT_COUNT_LSB-1:0];
	assign res_count = m_tdata[mhpq_pkg::OUT_COUNT_LSB+mhpq_pkg::COUNT_BITS-1:
		mhpq_pkg::OUT_COUNT_LSB];
	assign unused_in = ^{s_tdata, s_tuser};

	// A stalled result holds its payload.
	`MHPQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// One item at a time: an accepted item drops ready on the next cycle.
	`MHPQ_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready && !unused_in | s_tvalid && s_tready, !s_tready)

	// Failed operations return no entry.
	`MHPQ_ASSERT_IMPL(a_error_zero, m_tvalid && m_tuser != mhpq_pkg::ST_OK, res_entry == '0)

	// An empty status goes with an empty heap, a full status with a full one.
	`MHPQ_ASSERT_IMPL(a_empty_count, m_tvalid && m_tuser == mhpq_pkg::ST_EMPTY, res_count == '0)
	`MHPQ_ASSERT_IMPL(a_full_count, m_tvalid && m_tuser == mhpq_pkg::ST_FULL, res_count == mhpq_pkg::COUNT_BITS'(mhpq_pkg::DEPTH))

endmodule

bind min_heap_priority_queue_top mhpq_checker u_mhpq_checker (.*);
